[design/smsd_pkg.sv]
// Shared types and constants of the sample mean and standard deviation block.
package smsd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 33;
    localparam int SQ_W        = 47;
    localparam int CNT_W       = 17;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 63;
    localparam int DEN_W       = 32;
    localparam int RAD_W       = 32;
    localparam int ROOT_W      = 16;
    localparam int MREM_W      = 17;
    localparam int SREM_W      = 18;

    localparam logic [CNT_W-1:0] MAX_SAMPLES = 17'd65536;

    // Serial step counts: one multiplier bit, one quotient bit, one root bit per cycle
    localparam int MUL_STEPS   = MAG_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int MUL_STEP_W  = $clog2(MUL_STEPS);
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);
    localparam int ROOT_STEP_W = $clog2(ROOT_STEPS);

    localparam int OUT_DATA_W  = 56;

    localparam logic [SAMPLE_W-1:0] MEAN_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] MEAN_NEG_MIN = 16'h8000;
    localparam logic [ROOT_W-1:0]   SD_MAX       = 16'hFFFF;

    // Closed set handed from the accumulator to the finishing units
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } t_set;

    // Per-set moments: numerator n*Q - S^2, denominator n*(n-1), clamped mean
    typedef struct packed {
        logic [PROD_W-1:0]   num;
        logic [DEN_W-1:0]    den;
        logic [SAMPLE_W-1:0] mean;
    } t_mom;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

[design/smsd_accum.sv]
// Running sum, sum of squares and count, one sample per transfer.
module smsd_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [smsd_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_last,
    output logic                           o_close,
    output smsd_pkg::t_set                 o_set
);
    import smsd_pkg::*;

    logic [SUM_W-1:0]    r_running_sum, n_running_sum;
    logic [SQ_W-1:0]     r_running_square_sum, n_running_square_sum;
    logic [CNT_W-1:0]    r_items_seen, n_items_seen;
    logic                r_close;
    t_set                r_set;
    logic signed [31:0]  w_square;
    logic                w_close;

    // Square and add the new sample
    assign w_square             = $signed(i_sample) * $signed(i_sample);
    assign n_running_sum        = r_running_sum
                                  + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign n_running_square_sum = r_running_square_sum + {15'd0, 32'(w_square)};
    assign n_items_seen         = r_items_seen + 17'd1;
    assign w_close              = i_take && (i_last || n_items_seen == MAX_SAMPLES);

    // Advance the sums; on close hand the set over and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum        <= '0;
            r_running_square_sum <= '0;
            r_items_seen         <= '0;
            r_close              <= 1'b0;
        end else begin
            r_close <= w_close;
            if (w_close) begin
                r_running_sum        <= '0;
                r_running_square_sum <= '0;
                r_items_seen         <= '0;
            end else if (i_take) begin
                r_running_sum        <= n_running_sum;
                r_running_square_sum <= n_running_square_sum;
                r_items_seen         <= n_items_seen;
            end
        end
    end

    // Snapshot of the closed set
    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_set.sum <= n_running_sum;
            r_set.sq  <= n_running_square_sum;
            r_set.cnt <= n_items_seen;
        end
    end

    assign o_close = r_close;
    assign o_set   = r_set;

endmodule

[design/smsd_moments.sv]
// Bit-serial products n*Q, S*S, n*(n-1) and the serial mean divide S/n.
module smsd_moments (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  smsd_pkg::t_set       i_set,
    output smsd_pkg::t_unit_stat o_stat,
    output smsd_pkg::t_mom       o_mom
);
    import smsd_pkg::*;

    logic                  r_busy, r_done;
    logic [MUL_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_n, r_mpl_n;
    logic [MAG_W-1:0]      r_mpl_s;
    logic [PROD_W-1:0]     r_mc_q, r_mc_s, r_acc_nq, r_acc_ss;
    logic [DEN_W-1:0]      r_mc_d, r_acc_d;
    logic [MAG_W-1:0]      r_dvd;
    logic [MREM_W-1:0]     r_rem;
    logic                  r_neg;
    logic                  w_neg;
    logic [SUM_W-1:0]      w_abs;
    logic [MREM_W:0]       w_rem_t;
    logic                  w_ge;
    logic [SAMPLE_W-1:0]   w_mean;

    assign w_neg   = i_set.sum[SUM_W-1];
    assign w_abs   = w_neg ? (SUM_W'(0) - i_set.sum) : i_set.sum;
    assign w_rem_t = {r_rem, r_dvd[MAG_W-1]};
    assign w_ge    = w_rem_t >= {1'b0, r_n};

    // Load operands, then one multiplier bit and one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == MUL_STEP_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n      <= i_set.cnt;
            r_mpl_n  <= i_set.cnt;
            r_mpl_s  <= w_abs[MAG_W-1:0];
            r_mc_q   <= {{(PROD_W-SQ_W){1'b0}}, i_set.sq};
            r_mc_s   <= {{(PROD_W-MAG_W){1'b0}}, w_abs[MAG_W-1:0]};
            r_mc_d   <= {{(DEN_W-CNT_W){1'b0}}, i_set.cnt - 17'd1};
            r_acc_nq <= '0;
            r_acc_ss <= '0;
            r_acc_d  <= '0;
            r_dvd    <= w_abs[MAG_W-1:0];
            r_rem    <= '0;
            r_neg    <= w_neg;
        end else if (r_busy) begin
            if (r_mpl_n[0]) begin
                r_acc_nq <= r_acc_nq + r_mc_q;
                r_acc_d  <= r_acc_d + r_mc_d;
            end
            if (r_mpl_s[0]) begin
                r_acc_ss <= r_acc_ss + r_mc_s;
            end
            r_mpl_n <= r_mpl_n >> 1;
            r_mpl_s <= r_mpl_s >> 1;
            r_mc_q  <= r_mc_q << 1;
            r_mc_s  <= r_mc_s << 1;
            r_mc_d  <= r_mc_d << 1;
            r_rem   <= w_ge ? MREM_W'(w_rem_t - {1'b0, r_n}) : w_rem_t[MREM_W-1:0];
            r_dvd   <= {r_dvd[MAG_W-2:0], w_ge};
        end
    end

    // Apply the sign and clamp the mean to 16 bits
    always_comb begin
        if (!r_neg) begin
            w_mean = (r_dvd > {16'd0, MEAN_POS_MAX}) ? MEAN_POS_MAX : r_dvd[SAMPLE_W-1:0];
        end else begin
            w_mean = (r_dvd > {16'd0, MEAN_NEG_MIN}) ? MEAN_NEG_MIN
                                                      : SAMPLE_W'(16'd0 - r_dvd[15:0]);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_mom.num   = r_acc_nq - r_acc_ss;
    assign o_mom.den   = r_acc_d;
    assign o_mom.mean  = w_mean;

    // n*Q never falls below S*S for an exact set
    a_num_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_acc_ss <= r_acc_nq)
        else $error("moments: S*S exceeds n*Q");

    // Denominator is n*(n-1)
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> {32'd0, r_acc_d} == 64'(r_n) * 64'(r_n - 17'd1))
        else $error("moments: wrong denominator");

endmodule

[design/smsd_vardiv.sv]
// Restoring divider, one quotient bit per cycle: (n*Q - S^2) / (n*(n-1)).
module smsd_vardiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smsd_pkg::PROD_W-1:0]   i_num,
    input  logic [smsd_pkg::DEN_W-1:0]    i_den,
    output smsd_pkg::t_unit_stat          o_stat,
    output logic [smsd_pkg::PROD_W-1:0]   o_quot
);
    import smsd_pkg::*;

    logic                  r_busy, r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [DEN_W-1:0]      r_den;
    logic [PROD_W-1:0]     r_partial_quotient;
    logic [DEN_W-1:0]      r_divide_remainder;
    logic [DEN_W:0]        w_rem_t;
    logic                  w_ge;

    assign w_rem_t = {r_divide_remainder, r_partial_quotient[PROD_W-1]};
    assign w_ge    = w_rem_t >= {1'b0, r_den};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out at the top and the quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den              <= i_den;
            r_partial_quotient <= i_num;
            r_divide_remainder <= '0;
        end else if (r_busy) begin
            r_divide_remainder <= w_ge ? DEN_W'(w_rem_t - {1'b0, r_den})
                                       : w_rem_t[DEN_W-1:0];
            r_partial_quotient <= {r_partial_quotient[PROD_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_partial_quotient;

    // Final remainder stays below the divisor
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_divide_remainder < r_den)
        else $error("vardiv: remainder not below divisor");

endmodule

[design/smsd_isqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module smsd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smsd_pkg::RAD_W-1:0]    i_rad,
    output smsd_pkg::t_unit_stat          o_stat,
    output logic [smsd_pkg::ROOT_W-1:0]   o_root
);
    import smsd_pkg::*;

    logic                   r_busy, r_done;
    logic [ROOT_STEP_W-1:0] r_step;
    logic [RAD_W-1:0]       r_rad;
    logic [SREM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]      r_partial_root;
    logic [SREM_W+1:0]      w_rem_t, w_trial;
    logic                   w_ge;

    assign w_rem_t = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_partial_root, 2'b01};
    assign w_ge    = w_rem_t >= w_trial;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == ROOT_STEP_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Bring down two radicand bits, try root*4+1, keep or drop
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad          <= i_rad;
            r_rem          <= '0;
            r_partial_root <= '0;
        end else if (r_busy) begin
            r_rad          <= r_rad << 2;
            r_rem          <= w_ge ? SREM_W'(w_rem_t - w_trial) : w_rem_t[SREM_W-1:0];
            r_partial_root <= {r_partial_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_partial_root;

endmodule

[design/sample_mean_stddev.sv]
// Top level: sample mean and sample standard deviation over sets of Q8.8 samples.
// Throughput: one sample per cycle while a set accumulates; tready stays low until the load.
// Sequence: after the closing transfer come start, 32 product and mean steps, 63 divide steps,
//   16 root steps, the handoffs and the output load; a single sample skips divide and root.
//   A result not yet taken holds the load back until the output register frees.
// Reset: synchronous, active low; clears sums, count, sequencer and output valid.
module sample_mean_stddev (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    input  logic        i_s_tlast,   // last_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [15:0] mean_value, [31:16] std_deviation,
                                     // [48:32] sample_count, [55:49] zero
    output logic        o_m_tuser    // deviation_undefined
);
    import smsd_pkg::*;

    typedef enum logic [2:0] {S_ACC, S_MOM, S_DIV, S_ROOT, S_OUT} t_state;

    t_state              r_state;
    logic                w_take, w_close;
    t_set                w_set;
    t_mom                w_mom;
    t_unit_stat          w_mom_stat, w_div_stat, w_root_stat;
    logic [PROD_W-1:0]   w_quot;
    logic [ROOT_W-1:0]   w_root;
    logic                w_mom_start, w_div_start, w_root_start;
    logic [CNT_W-1:0]    r_cnt;
    logic [ROOT_W-1:0]   r_sd;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [ROOT_W-1:0]   r_out_sd;
    logic [CNT_W-1:0]    r_out_cnt;
    logic                r_out_undef;
    logic                w_undef;

    assign o_s_tready   = (r_state == S_ACC) && !w_close;
    assign w_take       = i_s_tvalid && o_s_tready;
    assign w_mom_start  = (r_state == S_ACC) && w_close;
    assign w_div_start  = (r_state == S_MOM) && w_mom_stat.done && (r_cnt != 17'd1);
    assign w_root_start = (r_state == S_DIV) && w_div_stat.done
                          && (w_quot[PROD_W-1:RAD_W] == '0);
    assign w_undef      = (r_cnt == 17'd1);

    smsd_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_sample (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_close  (w_close),
        .o_set    (w_set)
    );

    smsd_moments u_moments (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mom_start),
        .i_set   (w_set),
        .o_stat  (w_mom_stat),
        .o_mom   (w_mom)
    );

    smsd_vardiv u_vardiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mom.num),
        .i_den   (w_mom.den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    smsd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_rad   (w_quot[RAD_W-1:0]),
        .o_stat  (w_root_stat),
        .o_root  (w_root)
    );

    // Sequence the finishing units and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            // Drop valid once taken, unless a new result loads in this cycle
            if (r_out_valid && i_m_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (w_close) begin
                        r_cnt   <= w_set.cnt;
                        r_state <= S_MOM;
                    end
                end
                S_MOM: begin
                    if (w_mom_stat.done) begin
                        if (w_undef) begin
                            r_sd    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        if (w_quot[PROD_W-1:RAD_W] != '0) begin
                            r_sd    <= SD_MAX;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (w_root_stat.done) begin
                        r_sd    <= w_root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_mean  <= w_mom.mean;
                        r_out_sd    <= r_sd;
                        r_out_cnt   <= r_cnt;
                        r_out_undef <= w_undef;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_cnt, r_out_sd, r_out_mean};
    assign o_m_tuser  = r_out_undef;

    // A single-sample result carries count one and zero deviation
    a_undef_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_undef |-> r_out_cnt == 17'd1 && r_out_sd == '0)
        else $error("top: undefined deviation with bad count or value");

    // No sample is taken while any finishing unit works
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_mom_stat.busy && !w_div_stat.busy && !w_root_stat.busy)
        else $error("top: sample taken while a set is being finished");

endmodule
